[design/acs_pkg.sv]
// Shared types, constants, microprogram and helpers for the accumulator CPU step block.
package acs_pkg;

    // Memory size; must be a power of two (index wrap is a bit-select).
    localparam int MEM_WORDS = 4096;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int WORD_W    = 16;
    localparam int UPC_W     = 4;

    typedef logic [UPC_W-1:0]  t_upc;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [MEM_AW-1:0] t_maddr;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_EXEC  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        OP_ST  = 3'd0,
        OP_LD  = 3'd1,
        OP_ADD = 3'd2,
        OP_BR  = 3'd3,
        OP_BZ  = 3'd4,
        OP_CLR = 3'd5,
        OP_DEC = 3'd6,
        OP_EXT = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        EX_HALT = 2'd0,
        EX_EI   = 2'd1,
        EX_DI   = 2'd2,
        EX_NOP  = 2'd3
    } t_ext;

    typedef enum logic [1:0] {
        MD_DIRECT  = 2'd0,
        MD_INDIR   = 2'd1,
        MD_INDEXED = 2'd2,
        MD_IDX_IND = 2'd3
    } t_mode;

    // Instruction word layout
    typedef struct packed {
        logic [3:0] spare;
        t_op        op;
        logic       sel;    // 1 ACC, 0 X
        t_mode      mode;
        logic [5:0] addr;
    } t_instr;

    // Memory address source
    typedef enum logic [2:0] {
        AS_NONE = 3'd0,
        AS_HOST = 3'd1,
        AS_PC   = 3'd2,
        AS_MODE = 3'd3,
        AS_EA   = 3'd4
    } t_asel;

    typedef enum logic [1:0] {
        EA_HOLD  = 2'd0,
        EA_MODE  = 2'd1,
        EA_RDATA = 2'd2
    } t_easel;

    typedef enum logic [2:0] {
        J_NEXT      = 3'd0,
        J_GOTO      = 3'd1,
        J_IF_IND    = 3'd2,
        J_IF_NOTMEM = 3'd3,
        J_DONE      = 3'd4
    } t_jmp;

    // One microcode control word
    typedef struct packed {
        t_asel  addr_sel;
        logic   mem_rd;
        logic   host_wr;
        logic   exec_op;
        logic   ir_load;
        t_easel ea_sel;
        logic   wb;
        logic   rd_out;
        t_jmp   jmp;
        t_upc   target;
    } t_uctl;

    // Jump conditions reported by the datapath
    typedef struct packed {
        logic ind;
        logic notmem;
    } t_cond;

    // Architectural state
    typedef struct packed {
        t_word pc;
        t_word acc;
        t_word x;
        logic  z;
        logic  ie;
        logic  h;
    } t_arch;

    typedef struct packed {
        logic   en;
        logic   we;
        t_maddr addr;
        t_word  wdata;
    } t_memreq;

    // Microprogram addresses
    localparam t_upc U_RET    = 4'd0;
    localparam t_upc U_RETRD  = 4'd1;
    localparam t_upc U_HWR    = 4'd2;
    localparam t_upc U_HRD    = 4'd3;
    localparam t_upc U_FETCH  = 4'd4;
    localparam t_upc U_DECODE = 4'd5;
    localparam t_upc U_EXEC   = 4'd6;
    localparam t_upc U_DATA   = 4'd7;
    localparam t_upc U_IND    = 4'd8;

    localparam t_uctl UC_NOP = '{
        addr_sel: AS_NONE, mem_rd: 1'b0, host_wr: 1'b0, exec_op: 1'b0,
        ir_load: 1'b0, ea_sel: EA_HOLD, wb: 1'b0, rd_out: 1'b0,
        jmp: J_DONE, target: U_RET
    };

    // Control store
    function automatic t_uctl ucode(t_upc u);
        t_uctl c;
        c = UC_NOP;
        unique case (u)
            U_RET: begin
                c.jmp = J_DONE;
            end
            U_RETRD: begin
                c.rd_out = 1'b1;
                c.jmp    = J_DONE;
            end
            U_HWR: begin
                c.addr_sel = AS_HOST;
                c.host_wr  = 1'b1;
                c.jmp      = J_GOTO;
                c.target   = U_RET;
            end
            U_HRD: begin
                c.addr_sel = AS_HOST;
                c.mem_rd   = 1'b1;
                c.jmp      = J_GOTO;
                c.target   = U_RETRD;
            end
            U_FETCH: begin
                c.addr_sel = AS_PC;
                c.mem_rd   = 1'b1;
                c.jmp      = J_NEXT;
            end
            U_DECODE: begin
                c.ir_load  = 1'b1;
                c.addr_sel = AS_MODE;
                c.mem_rd   = 1'b1;
                c.ea_sel   = EA_MODE;
                c.jmp      = J_IF_IND;
                c.target   = U_IND;
            end
            U_EXEC: begin
                c.addr_sel = AS_EA;
                c.exec_op  = 1'b1;
                c.jmp      = J_IF_NOTMEM;
                c.target   = U_RET;
            end
            U_DATA: begin
                c.wb     = 1'b1;
                c.jmp    = J_GOTO;
                c.target = U_RET;
            end
            U_IND: begin
                c.ea_sel = EA_RDATA;
                c.jmp    = J_GOTO;
                c.target = U_EXEC;
            end
            default: begin
                c = UC_NOP;
            end
        endcase
        return c;
    endfunction

    // Microprogram entry point for a request
    function automatic t_upc entry_upc(t_action a, logic halted);
        t_upc u;
        unique case (a)
            ACT_WRITE: u = U_HWR;
            ACT_READ:  u = U_HRD;
            ACT_EXEC:  u = halted ? U_RET : U_FETCH;
            ACT_NONE:  u = U_RET;
            default:   u = U_RET;
        endcase
        return u;
    endfunction

    function automatic t_maddr wrap_idx(t_word v);
        return v[MEM_AW-1:0];
    endfunction

endpackage

[design/acs_ram.sv]
// Generic single-port RAM with registered read.
module acs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/acs_useq.sv]
// Microsequencer: step counter, control store lookup and conditional jumps.
module acs_useq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  acs_pkg::t_upc    i_entry,
    input  acs_pkg::t_cond   i_cond,
    input  logic             i_stall,
    output acs_pkg::t_uctl   o_ctl,
    output logic             o_busy,
    output logic             o_done
);
    import acs_pkg::*;

    t_upc  r_upc;
    logic  r_busy;
    t_uctl w_word;

    assign w_word = ucode(r_upc);
    assign o_ctl  = r_busy ? w_word : UC_NOP;
    assign o_busy = r_busy;
    assign o_done = r_busy && (w_word.jmp == J_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_upc  <= U_RET;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_upc  <= i_entry;
        end else if (r_busy && !i_stall) begin
            unique case (w_word.jmp)
                J_NEXT:      r_upc <= r_upc + t_upc'(1);
                J_GOTO:      r_upc <= w_word.target;
                J_IF_IND:    r_upc <= i_cond.ind ? w_word.target : r_upc + t_upc'(1);
                J_IF_NOTMEM: r_upc <= i_cond.notmem ? w_word.target : r_upc + t_upc'(1);
                J_DONE:      r_busy <= 1'b0;
                default:     r_busy <= 1'b0;
            endcase
        end
    end

endmodule

[design/acs_dpath.sv]
// Datapath: ACC, X, PC, flags, instruction and effective address registers.
module acs_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  acs_pkg::t_uctl    i_ctl,
    input  acs_pkg::t_maddr   i_haddr,
    input  acs_pkg::t_word    i_hdata,
    input  acs_pkg::t_word    i_rdata,
    output acs_pkg::t_memreq  o_req,
    output acs_pkg::t_cond    o_cond,
    output acs_pkg::t_arch    o_arch
);
    import acs_pkg::*;

    t_arch  r_arch;
    t_arch  n_arch;
    t_word  r_ir;
    t_word  r_ea;
    t_instr w_in;
    t_word  w_a16;
    t_word  w_mode_ea;
    t_word  w_reg;
    t_word  w_dec;
    t_word  w_res;
    logic   w_indexed;
    logic   w_memop;
    t_ext   w_ext;

    // instruction comes straight from memory in the decode step
    assign w_in      = t_instr'(i_ctl.ir_load ? i_rdata : r_ir);
    assign w_ext     = t_ext'({w_in.sel, w_in.mode[1]});
    assign w_a16     = t_word'(w_in.addr);
    assign w_indexed = (w_in.mode == MD_INDEXED) || (w_in.mode == MD_IDX_IND);
    assign w_mode_ea = w_indexed ? w_a16 + r_arch.x : w_a16;
    assign w_reg     = w_in.sel ? r_arch.acc : r_arch.x;
    assign w_dec     = w_reg - t_word'(1);
    assign w_res     = (w_in.op == OP_LD) ? i_rdata : w_reg + i_rdata;
    assign w_memop   = (w_in.op == OP_ST) || (w_in.op == OP_LD) || (w_in.op == OP_ADD);

    assign o_cond.ind    = (w_in.mode == MD_INDIR) || (w_in.mode == MD_IDX_IND);
    assign o_cond.notmem = !((w_in.op == OP_LD) || (w_in.op == OP_ADD));

    always_comb begin
        o_req.en    = i_ctl.mem_rd || i_ctl.host_wr || (i_ctl.exec_op && w_memop);
        o_req.we    = i_ctl.host_wr || (i_ctl.exec_op && (w_in.op == OP_ST));
        o_req.wdata = i_ctl.host_wr ? i_hdata : w_reg;
        unique case (i_ctl.addr_sel)
            AS_HOST: o_req.addr = i_haddr;
            AS_PC:   o_req.addr = wrap_idx(r_arch.pc);
            AS_MODE: o_req.addr = wrap_idx(w_mode_ea);
            AS_EA:   o_req.addr = wrap_idx(r_ea);
            default: o_req.addr = '0;
        endcase
    end

    always_comb begin
        n_arch = r_arch;
        if (i_ctl.exec_op) begin
            n_arch.z  = 1'b0;
            n_arch.pc = r_arch.pc + t_word'(1);
            unique case (w_in.op)
                OP_ST, OP_LD, OP_ADD: ;
                OP_BR: n_arch.pc = r_ea;
                OP_BZ: begin
                    if (r_arch.z) begin
                        n_arch.pc = r_ea;
                    end
                end
                OP_CLR: begin
                    if (w_in.sel) n_arch.acc = '0;
                    else          n_arch.x   = '0;
                    n_arch.z = 1'b1;
                end
                OP_DEC: begin
                    if (w_in.sel) n_arch.acc = w_dec;
                    else          n_arch.x   = w_dec;
                    n_arch.z = (w_dec == '0);
                end
                OP_EXT: begin
                    unique case (w_ext)
                        EX_HALT: begin
                            n_arch.h  = 1'b1;
                            n_arch.pc = r_arch.pc;
                        end
                        EX_EI:   n_arch.ie = 1'b1;
                        EX_DI:   n_arch.ie = 1'b0;
                        EX_NOP:  ;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        if (i_ctl.wb) begin
            if (w_in.sel) n_arch.acc = w_res;
            else          n_arch.x   = w_res;
            n_arch.z = (w_res == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arch <= '0;
        end else begin
            r_arch <= n_arch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ir_load) begin
            r_ir <= i_rdata;
        end
        unique case (i_ctl.ea_sel)
            EA_MODE:  r_ea <= w_mode_ea;
            EA_RDATA: r_ea <= i_rdata;
            default:  r_ea <= r_ea;
        endcase
    end

    assign o_arch = r_arch;

endmodule

[design/accumulator_cpu_step.sv]
// Top level of the accumulator CPU step block: request/result handshake and memory.
// Each request runs as a microprogram: write, read, or execute (fetch, decode,
// an extra pointer step for an indirect mode, execute, and a data write-back
// step for ld/add); an execute while halted or an unused action only returns.
// One request is in work at a time; the single memory port is shared by fetch,
// pointer read and operand access. Reset: registers clear, then a pass over all
// MEM_WORDS (4096) words zeroes memory with o_in_ready low.
module accumulator_cpu_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [11:0] i_mem_addr,
    input  logic [15:0] i_write_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_prog_counter,
    output logic [15:0] o_accumulator,
    output logic [15:0] o_index_reg,
    output logic        o_zero_flag,
    output logic        o_int_enable,
    output logic        o_halted,
    output logic [15:0] o_read_data
);
    import acs_pkg::*;

    // Memory clearing pass after reset
    logic   r_clr;
    t_maddr r_clr_cnt;

    // Request operands latched at accept
    t_maddr r_haddr;
    t_word  r_hdata;

    // Result register
    logic   r_out_valid;
    t_arch  r_out_arch;
    t_word  r_out_rd;

    t_uctl   w_ctl;
    t_cond   w_cond;
    t_arch   w_arch;
    t_memreq w_req;
    t_word   w_rdata;
    logic    w_busy;
    logic    w_done;
    logic    w_start;
    logic    w_stall;
    logic    w_load;

    logic    w_ram_en;
    logic    w_ram_we;
    t_maddr  w_ram_addr;
    t_word   w_ram_wdata;

    assign o_in_ready = !w_busy && !r_clr;
    assign w_start    = i_in_valid && o_in_ready;

    // A finished request waits in its last microstep while the result register
    // is still occupied; that step has no side effects, so holding is safe.
    assign w_stall = w_done && r_out_valid && !i_out_ready;
    assign w_load  = w_done && !w_stall;

    acs_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_entry (entry_upc(t_action'(i_action), w_arch.h)),
        .i_cond  (w_cond),
        .i_stall (w_stall),
        .o_ctl   (w_ctl),
        .o_busy  (w_busy),
        .o_done  (w_done)
    );

    acs_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_haddr (r_haddr),
        .i_hdata (r_hdata),
        .i_rdata (w_rdata),
        .o_req   (w_req),
        .o_cond  (w_cond),
        .o_arch  (w_arch)
    );

    // Clearing pass owns the memory port until it finishes
    assign w_ram_en    = r_clr || w_req.en;
    assign w_ram_we    = r_clr || w_req.we;
    assign w_ram_addr  = r_clr ? r_clr_cnt : w_req.addr;
    assign w_ram_wdata = r_clr ? '0 : w_req.wdata;

    acs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_WORDS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_en    (w_ram_en),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= 1'b1;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_cnt <= r_clr_cnt + t_maddr'(1);
                if (r_clr_cnt == t_maddr'(MEM_WORDS - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_haddr <= wrap_idx(t_word'(i_mem_addr));
            r_hdata <= i_write_data;
        end
        if (w_load) begin
            r_out_arch <= w_arch;
            // read data is only reported by the read microprogram
            r_out_rd   <= w_ctl.rd_out ? w_rdata : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_prog_counter = r_out_arch.pc;
    assign o_accumulator  = r_out_arch.acc;
    assign o_index_reg    = r_out_arch.x;
    assign o_zero_flag    = r_out_arch.z;
    assign o_int_enable   = r_out_arch.ie;
    assign o_halted       = r_out_arch.h;
    assign o_read_data    = r_out_rd;

endmodule

[design/acs_chk.sv]
// Port-level checker for the accumulator CPU step block, with its bind.
module acs_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_action,
    input logic [11:0] i_mem_addr,
    input logic [15:0] i_write_data,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_prog_counter,
    input logic [15:0] o_accumulator,
    input logic [15:0] o_index_reg,
    input logic        o_zero_flag,
    input logic        o_int_enable,
    input logic        o_halted,
    input logic [15:0] o_read_data
);

    logic        r_seen_halt;
    logic [15:0] r_halt_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_halt <= 1'b0;
            r_halt_pc   <= '0;
        end else if (o_out_valid && i_out_ready && o_halted && !r_seen_halt) begin
            r_seen_halt <= 1'b1;
            r_halt_pc   <= o_prog_counter;
        end
    end

    // memory clearing keeps requests out right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("request accepted during memory clear");

    // a waiting request holds its payload
    a_request_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_action)
            && $stable(i_mem_addr) && $stable(i_write_data))
        else $error("request changed while waiting");

    // stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_prog_counter)
            && $stable(o_accumulator) && $stable(o_index_reg) && $stable(o_zero_flag)
            && $stable(o_int_enable) && $stable(o_halted) && $stable(o_read_data))
        else $error("result changed while stalled");

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen_halt |-> o_halted)
        else $error("halt flag dropped");

    // a halted machine never moves its program counter
    a_halt_pc_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen_halt |-> o_prog_counter == r_halt_pc)
        else $error("program counter moved while halted");

endmodule

bind accumulator_cpu_step acs_chk u_acs_chk (.*);
